[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define MHF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define MHF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mhf_pkg.sv]
package mhf_pkg;

   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
   localparam int          MAC_BYTES  = 6;
   localparam int          MAC_WIDTH  = 48;
   localparam int          IDX_WIDTH  = 6;
   localparam int          GRP_WIDTH  = 3;
   localparam int          TBL_WIDTH  = 64;
   localparam int          WORD_WIDTH = 32;
   localparam logic [2:0]  LAST_BYTE  = 3'(MAC_BYTES - 1);

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_CRC,
      FRONT_PUSH
   } front_state_type;

   typedef struct packed {
      logic                 valid;
      logic [IDX_WIDTH-1:0] bit_index;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // One byte of the reflected CRC, eight shift steps.
   function automatic logic [31:0] crc_byte_step(input logic [31:0] crc,
                                                 input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'h0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/core/mhf_front.sv]
module mhf_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mhf_pkg::MAC_WIDTH-1:0]      req_mac_address,
   input  mhf_pkg::queue_status_type          qstat,
   output logic                               busy,
   output mhf_pkg::push_type                  push
);

   mhf_pkg::front_state_type state_ff, state_in;
   logic [mhf_pkg::MAC_WIDTH-1:0] addr_ff, addr_in;
   logic [31:0]                   crc_ff, crc_in;
   logic [2:0]                    cnt_ff, cnt_in;
   logic                          accept;

   assign accept = start && (state_ff == mhf_pkg::FRONT_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhf_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      addr_ff <= addr_in;
      crc_ff  <= crc_in;
      cnt_ff  <= cnt_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mhf_pkg::FRONT_IDLE: begin
            if (start) state_in = mhf_pkg::FRONT_CRC;
         end
         mhf_pkg::FRONT_CRC: begin
            if (cnt_ff == mhf_pkg::LAST_BYTE) state_in = mhf_pkg::FRONT_PUSH;
         end
         mhf_pkg::FRONT_PUSH: begin
            if (!qstat.full) state_in = mhf_pkg::FRONT_IDLE;
         end
         default: state_in = mhf_pkg::FRONT_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      addr_in        = addr_ff;
      crc_in         = crc_ff;
      cnt_in         = cnt_ff;
      busy           = 1'b1;
      push.valid     = 1'b0;
      push.bit_index = crc_ff[mhf_pkg::IDX_WIDTH-1:0];
      case (state_ff)
         mhf_pkg::FRONT_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               addr_in = req_mac_address;
               crc_in  = mhf_pkg::CRC_INIT;
               cnt_in  = 3'd0;
            end
         end
         mhf_pkg::FRONT_CRC: begin
            // consume the low byte, first transmitted first
            crc_in  = mhf_pkg::crc_byte_step(crc_ff, addr_ff[7:0]);
            addr_in = addr_ff >> 8;
            cnt_in  = cnt_ff + 3'd1;
         end
         mhf_pkg::FRONT_PUSH: begin
            push.valid = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

[rtl/core/mhf_queue.sv]
module mhf_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  mhf_pkg::push_type                 push,
   input  logic                              pop,
   output logic [mhf_pkg::IDX_WIDTH-1:0]     head_index,
   output mhf_pkg::queue_status_type         qstat
);

   logic [mhf_pkg::IDX_WIDTH-1:0] entries_ff [2];
   logic                          wr_ptr_ff, wr_ptr_in;
   logic                          rd_ptr_ff, rd_ptr_in;
   logic [1:0]                    count_ff, count_in;
   logic                          do_push, do_pop;

   assign qstat.full  = (count_ff == 2'd2);
   assign qstat.empty = (count_ff == 2'd0);
   assign do_push     = push.valid && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_index  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entries_ff[wr_ptr_ff] <= push.bit_index;
   end

endmodule

[rtl/core/mhf_back.sv]
module mhf_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [mhf_pkg::IDX_WIDTH-1:0]      head_index,
   input  mhf_pkg::queue_status_type          qstat,
   output logic                               pop,
   output logic                               rsp_strobe,
   output logic [mhf_pkg::IDX_WIDTH-1:0]      rsp_bit_index,
   output logic [mhf_pkg::GRP_WIDTH-1:0]      rsp_byte_group,
   output logic [7:0]                         rsp_byte_value,
   output logic [mhf_pkg::WORD_WIDTH-1:0]     rsp_table_low_word,
   output logic [mhf_pkg::WORD_WIDTH-1:0]     rsp_table_high_word
);

   logic [mhf_pkg::TBL_WIDTH-1:0] table_ff, table_in;
   logic                          strobe_ff;
   logic [mhf_pkg::IDX_WIDTH-1:0] index_ff;
   logic [7:0]                    byte_ff, byte_in;
   logic [mhf_pkg::GRP_WIDTH-1:0] grp;

   // results cannot be held off, so drain whenever something is queued
   assign pop = !qstat.empty;
   assign grp = head_index[mhf_pkg::IDX_WIDTH-1 -: mhf_pkg::GRP_WIDTH];

   always_comb begin
      table_in = table_ff;
      if (pop) table_in[head_index] = 1'b1;
      byte_in = table_in[{grp, 3'b000} +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         table_ff  <= table_in;
         strobe_ff <= pop;
      end
      if (pop) begin
         index_ff <= head_index;
         byte_ff  <= byte_in;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_bit_index       = index_ff;
   assign rsp_byte_group      = index_ff[mhf_pkg::IDX_WIDTH-1 -: mhf_pkg::GRP_WIDTH];
   assign rsp_byte_value      = byte_ff;
   assign rsp_table_low_word  = table_ff[mhf_pkg::WORD_WIDTH-1:0];
   assign rsp_table_high_word = table_ff[mhf_pkg::TBL_WIDTH-1:mhf_pkg::WORD_WIDTH];

endmodule

[rtl/core/multicast_hash_filter_update.sv]
// Multicast hash filter update. Pulse start with a 48-bit MAC address (first
// transmitted byte in bits 7:0) while busy is low; the block forms the
// reflected CRC-32 of the six bytes and sets table bit crc[5:0] in a 64-bit
// hash table that reset clears. Each address gives one result beat, shown
// for exactly one cycle with rsp_strobe, that the receiver cannot stall:
// bit index, byte group, new table byte and both table words after the
// update. The front unit folds in one address byte per cycle and takes no new
// address until the last one is pushed; a two-entry queue parts the CRC unit
// from the table unit, whose registers hold the result beat on the ports.
module multicast_hash_filter_update (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [mhf_pkg::MAC_WIDTH-1:0]      req_mac_address,
   output logic                               rsp_strobe,
   output logic [mhf_pkg::IDX_WIDTH-1:0]      rsp_bit_index,
   output logic [mhf_pkg::GRP_WIDTH-1:0]      rsp_byte_group,
   output logic [7:0]                         rsp_byte_value,
   output logic [mhf_pkg::WORD_WIDTH-1:0]     rsp_table_low_word,
   output logic [mhf_pkg::WORD_WIDTH-1:0]     rsp_table_high_word
);

   mhf_pkg::push_type             push;
   mhf_pkg::queue_status_type     qstat;
   logic [mhf_pkg::IDX_WIDTH-1:0] head_index;
   logic                          pop;

   mhf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_mac_address (req_mac_address),
      .qstat           (qstat),
      .busy            (busy),
      .push            (push)
   );

   mhf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head_index (head_index),
      .qstat      (qstat)
   );

   mhf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_index          (head_index),
      .qstat               (qstat),
      .pop                 (pop),
      .rsp_strobe          (rsp_strobe),
      .rsp_bit_index       (rsp_bit_index),
      .rsp_byte_group      (rsp_byte_group),
      .rsp_byte_value      (rsp_byte_value),
      .rsp_table_low_word  (rsp_table_low_word),
      .rsp_table_high_word (rsp_table_high_word)
   );

endmodule

[rtl/core/mhf_checker.sv]
`include "assert_macros.svh"

module mhf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic [mhf_pkg::MAC_WIDTH-1:0]      req_mac_address,
   input logic                               rsp_strobe,
   input logic [mhf_pkg::IDX_WIDTH-1:0]      rsp_bit_index,
   input logic [mhf_pkg::GRP_WIDTH-1:0]      rsp_byte_group,
   input logic [7:0]                         rsp_byte_value,
   input logic [mhf_pkg::WORD_WIDTH-1:0]     rsp_table_low_word,
   input logic [mhf_pkg::WORD_WIDTH-1:0]     rsp_table_high_word
);

   logic [mhf_pkg::TBL_WIDTH-1:0] tbl;
   logic [7:0]                    tbl_byte;
   logic                          accepted;
   logic                          addr_seen;

   assign tbl       = {rsp_table_high_word, rsp_table_low_word};
   assign tbl_byte  = tbl[{rsp_byte_group, 3'b000} +: 8];
   assign accepted  = start && !busy;
   assign addr_seen = ^req_mac_address || !(^req_mac_address);

   `MHF_ASSERT(a_group_matches, clock, reset, rsp_strobe |-> (rsp_byte_group == rsp_bit_index[5:3]), "byte group does not match bit index")
   `MHF_ASSERT(a_byte_matches, clock, reset, rsp_strobe |-> (rsp_byte_value == tbl_byte && tbl[rsp_bit_index]), "reported byte disagrees with table")
   `MHF_ASSERT(a_busy_after_accept, clock, reset, (accepted && addr_seen) |=> busy, "no busy after an accepted beat")
   `MHF_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_strobe, "result beat straight after reset")

endmodule

bind multicast_hash_filter_update mhf_checker u_mhf_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_ITEMS = 1534;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 30;
   localparam int PRINT_CAP    = 50;

   typedef struct packed {
      logic [mhf_pkg::IDX_WIDTH-1:0]  bit_index;
      logic [mhf_pkg::GRP_WIDTH-1:0]  byte_group;
      logic [7:0]                     byte_value;
      logic [mhf_pkg::WORD_WIDTH-1:0] low_word;
      logic [mhf_pkg::WORD_WIDTH-1:0] high_word;
   } table_update_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [mhf_pkg::MAC_WIDTH-1:0]  req_mac_address = '0;
   logic                           rsp_strobe;
   logic [mhf_pkg::IDX_WIDTH-1:0]  rsp_bit_index;
   logic [mhf_pkg::GRP_WIDTH-1:0]  rsp_byte_group;
   logic [7:0]                     rsp_byte_value;
   logic [mhf_pkg::WORD_WIDTH-1:0] rsp_table_low_word;
   logic [mhf_pkg::WORD_WIDTH-1:0] rsp_table_high_word;

   logic [mhf_pkg::MAC_WIDTH-1:0] pending_macs[$];
   table_update_type              table_updates_due[$];
   logic [mhf_pkg::TBL_WIDTH-1:0] table_model = '0;

   int directed_count;
   int total_items;
   int n_accepted     = 0;
   int n_received     = 0;
   int mismatch_count = 0;
   int repeat_hits    = 0;
   int cycle_count    = 0;
   int gap_left       = 0;
   bit drain_hold     = 1'b0;

   multicast_hash_filter_update dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mac_address     (req_mac_address),
      .rsp_strobe          (rsp_strobe),
      .rsp_bit_index       (rsp_bit_index),
      .rsp_byte_group      (rsp_byte_group),
      .rsp_byte_value      (rsp_byte_value),
      .rsp_table_low_word  (rsp_table_low_word),
      .rsp_table_high_word (rsp_table_high_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Reflected CRC-32, one address bit per step, first byte's LSB first.
   function automatic logic [31:0] mac_crc(input logic [mhf_pkg::MAC_WIDTH-1:0] mac);
      logic [31:0] c;
      logic        fb;
      c = mhf_pkg::CRC_INIT;
      for (int i = 0; i < mhf_pkg::MAC_WIDTH; i++) begin
         fb = c[0] ^ mac[i];
         c  = c >> 1;
         if (fb) begin
            c = c ^ mhf_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic table_update_type predict_table_update(
      input logic [mhf_pkg::MAC_WIDTH-1:0] mac);
      table_update_type u;
      logic [31:0]      crc;
      crc          = mac_crc(mac);
      u.bit_index  = crc[mhf_pkg::IDX_WIDTH-1:0];
      u.byte_group = u.bit_index[mhf_pkg::IDX_WIDTH-1:3];
      if (table_model[u.bit_index]) begin
         repeat_hits++;
      end
      table_model[u.bit_index] = 1'b1;
      u.byte_value = table_model[8*u.byte_group +: 8];
      u.low_word   = table_model[mhf_pkg::WORD_WIDTH-1:0];
      u.high_word  = table_model[mhf_pkg::TBL_WIDTH-1:mhf_pkg::WORD_WIDTH];
      return u;
   endfunction

   function automatic int pick_gap(input int count);
      int r;
      // hold back-to-back for a stretch every few hundred beats
      if ((count / 200) % 3 == 1) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_CAP) begin
         $display("%0t: beat %0d %s: got 0x%0h, want 0x%0h",
                  $realtime, n_received, what, got, want);
      end
      mismatch_count++;
   endtask

   // Driver: one beat per accepted start, next address from the pending queue.
   always @(posedge clock) begin : driver
      logic                          took;
      logic                          next_start;
      logic [mhf_pkg::MAC_WIDTH-1:0] next_mac;
      if (reset) begin
         start    <= 1'b0;
         gap_left =  0;
      end else begin
         took       = start && !busy;
         next_start = start;
         next_mac   = req_mac_address;
         if (took) begin
            table_updates_due.push_back(predict_table_update(req_mac_address));
            n_accepted <= n_accepted + 1;
            gap_left   =  pick_gap(n_accepted);
            next_start =  1'b0;
            if (n_accepted + 1 == directed_count || n_accepted + 1 == 700 ||
                n_accepted + 1 == 1300) begin
               drain_hold = 1'b1;
            end
         end
         if (!next_start) begin
            if (drain_hold) begin
               if (!took && n_accepted == n_received) begin
                  drain_hold = 1'b0;
               end
            end else if (gap_left > 0) begin
               gap_left--;
            end else if (pending_macs.size() > 0) begin
               next_mac   = pending_macs.pop_front();
               next_start = 1'b1;
            end
         end
         start           <= next_start;
         req_mac_address <= next_mac;
      end
   end

   always @(posedge clock) begin : monitor
      table_update_type want;
      if (!reset && rsp_strobe) begin
         if (table_updates_due.size() == 0) begin
            report_mismatch("unexpected beat, bit_index", 32'(rsp_bit_index), '0);
         end else begin
            want = table_updates_due.pop_front();
            if (rsp_bit_index !== want.bit_index)
               report_mismatch("bit_index", 32'(rsp_bit_index), 32'(want.bit_index));
            if (rsp_byte_group !== want.byte_group)
               report_mismatch("byte_group", 32'(rsp_byte_group), 32'(want.byte_group));
            if (rsp_byte_value !== want.byte_value)
               report_mismatch("byte_value", 32'(rsp_byte_value), 32'(want.byte_value));
            if (rsp_table_low_word !== want.low_word)
               report_mismatch("table_low_word", rsp_table_low_word, want.low_word);
            if (rsp_table_high_word !== want.high_word)
               report_mismatch("table_high_word", rsp_table_high_word, want.high_word);
            n_received <= n_received + 1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("cycle limit hit: %0d beats in, %0d out", n_accepted, n_received);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [mhf_pkg::MAC_WIDTH-1:0] mac;
      int                            r;
      // field extremes, well-known group addresses and repeats
      pending_macs.push_back(48'h0000_0000_0000);
      pending_macs.push_back(48'hFFFF_FFFF_FFFF);
      pending_macs.push_back(48'h0100_005E_0001);
      pending_macs.push_back(48'h0100_0000_3333);
      pending_macs.push_back(48'hFB00_005E_0001);
      pending_macs.push_back(48'h0100_005E_0001);
      pending_macs.push_back(48'h5555_5555_5555);
      pending_macs.push_back(48'hAAAA_AAAA_AAAA);
      pending_macs.push_back(48'h0000_0000_0001);
      pending_macs.push_back(48'h8000_0000_0000);
      pending_macs.push_back(48'h0000_0000_00FF);
      pending_macs.push_back(48'hFF00_0000_0000);
      pending_macs.push_back(48'h0000_FFFF_0000);
      pending_macs.push_back(48'hFFFF_FFFF_FFFE);
      pending_macs.push_back(48'h0000_0000_0000);
      pending_macs.push_back(48'hFFFF_FFFF_FFFF);
      directed_count = pending_macs.size();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         r   = $urandom_range(0, 99);
         mac = {16'($urandom), 32'($urandom)};
         if (r < 80) begin
            mac[0] = 1'b1;
         end else if (r < 90 && pending_macs.size() > 0) begin
            // resend an earlier address so its bit is already set
            mac = pending_macs[$urandom_range(0, pending_macs.size() - 1)];
         end
         pending_macs.push_back(mac);
      end
      total_items = pending_macs.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted != total_items) @(posedge clock);
      while (table_updates_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d addresses hashed (%0d directed), %0d result beats checked",
               n_accepted, directed_count, n_received);
      $display("%0d hits on bits already set, %0d of %0d table bits set at the end",
               repeat_hits, $countones(table_model), mhf_pkg::TBL_WIDTH);
      if (mismatch_count == 0 && table_updates_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
